// File: src/c8ie_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8ie_pkg: shared types and constants for the CHIP-8 instruction executor
// Opcode groups, sub-codes, status codes, register indexes and the decoded
// execution record passed from the execute logic to the state registers.
// ----------------------------------------------------------------------------
package c8ie_pkg;

    localparam int OPCODE_W  = 16;
    localparam int RANDOM_W  = 8;
    localparam int ADDR_W    = 12;
    localparam int BYTE_W    = 8;
    localparam int REGIDX_W  = 4;
    localparam int VREG_COUNT = 16;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 64;

    localparam logic [ADDR_W-1:0] START_ADDR_RESET = 12'h200;
    localparam logic [ADDR_W-1:0] INSTR_BYTES      = 12'd2;
    localparam logic [ADDR_W-1:0] SKIP_BYTES       = 12'd4;

    localparam logic [REGIDX_W-1:0] REG_V0 = 4'h0;
    localparam logic [REGIDX_W-1:0] REG_VF = 4'hF;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_UNDERFLOW = 2'd3
    } status_t;

    // Top nibble of the instruction word.
    localparam logic [3:0] GRP_SYS   = 4'h0;
    localparam logic [3:0] GRP_JP    = 4'h1;
    localparam logic [3:0] GRP_CALL  = 4'h2;
    localparam logic [3:0] GRP_SE_NN = 4'h3;
    localparam logic [3:0] GRP_SNE_NN = 4'h4;
    localparam logic [3:0] GRP_SE_XY = 4'h5;
    localparam logic [3:0] GRP_LD_NN = 4'h6;
    localparam logic [3:0] GRP_ADD_NN = 4'h7;
    localparam logic [3:0] GRP_ALU   = 4'h8;
    localparam logic [3:0] GRP_SNE_XY = 4'h9;
    localparam logic [3:0] GRP_LD_I  = 4'hA;
    localparam logic [3:0] GRP_JP_V0 = 4'hB;
    localparam logic [3:0] GRP_RND   = 4'hC;
    localparam logic [3:0] GRP_DRAW  = 4'hD;
    localparam logic [3:0] GRP_KEY   = 4'hE;
    localparam logic [3:0] GRP_MISC  = 4'hF;

    localparam logic [OPCODE_W-1:0] OP_CLS = 16'h00E0;
    localparam logic [OPCODE_W-1:0] OP_RET = 16'h00EE;

    // Low nibble of the ALU group.
    localparam logic [3:0] ALU_LD   = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    // Low byte of the key group.
    localparam logic [7:0] KEY_SKP  = 8'h9E;
    localparam logic [7:0] KEY_SKNP = 8'hA1;

    // Low byte of the misc group.
    localparam logic [7:0] MISC_LD_VX_DT = 8'h07;
    localparam logic [7:0] MISC_LD_KEY   = 8'h0A;
    localparam logic [7:0] MISC_LD_DT    = 8'h15;
    localparam logic [7:0] MISC_LD_ST    = 8'h18;
    localparam logic [7:0] MISC_ADD_I    = 8'h1E;
    localparam logic [7:0] MISC_LD_FONT  = 8'h29;
    localparam logic [7:0] MISC_BCD      = 8'h33;
    localparam logic [7:0] MISC_STORE    = 8'h55;
    localparam logic [7:0] MISC_LOAD     = 8'h65;

    // Everything one instruction does to the machine state.
    typedef struct packed {
        status_t            status;
        logic [ADDR_W-1:0]  npc;
        logic               vx_wr_en;
        logic [BYTE_W-1:0]  vx_val;
        logic               vf_wr_en;
        logic [BYTE_W-1:0]  vf_val;
        logic               idx_wr_en;
        logic [ADDR_W-1:0]  idx_val;
        logic               dt_wr_en;
        logic               st_wr_en;
        logic               push;
        logic               pop;
        logic               clr;
        logic               draw;
    } exec_t;

    // Stack condition seen by the execute logic.
    typedef struct packed {
        logic               empty;
        logic               full;
        logic [ADDR_W-1:0]  tos;
    } stack_stat_t;

endpackage

// File: src/chip8_instruction_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_instruction_execute: CHIP-8 instruction executor
// Executes one CHIP-8 instruction per input beat and reports the resulting
// machine state as one output beat.
// ----------------------------------------------------------------------------
// The block executes one instruction per clock cycle, sustained while the
// receiver takes results, with no bubbles between back-to-back instructions.
// A beat accepted on s_ lands in an input register, together with VX and VY
// read from the register file; when the result register is free or being
// emptied, the single execute stage decodes it, updates the machine state
// and loads the result register. The rate is set by that one execute
// stage: register file reads are done at acceptance with forwarding from the
// instruction executing in the same cycle, and the return stack keeps its top
// entry in a register with the next entry prefetched from its memory. The
// input side keeps accepting while a finished result waits on m_tready; only
// when both the input and result registers are full does s_tready drop.
// Reset clears V0..VF, I, the timers and the stack pointer, returns the
// start address register to its default of 0x200 and loads the PC from it.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module chip8_instruction_execute #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [11:0] cfg_wr_data,      // start_address

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,          // [15:0] opcode, [23:16] random_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata           // [1:0] status, [13:2] next_pc,
                                          // [25:14] index_value, [29:26] dest_reg,
                                          // [37:30] dest_value, [45:38] flag_value,
                                          // [46] clear_screen, [47] draw_request,
                                          // [55:48] delay_value, [63:56] sound_value
);
    import c8ie_pkg::*;

    // Start address register and the program-visible state.
    logic [ADDR_W-1:0] start_addr_reg, start_addr_next;
    logic [ADDR_W-1:0] pc_reg, pc_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [BYTE_W-1:0] dt_reg, dt_next;
    logic [BYTE_W-1:0] st_reg, st_next;
    logic [BYTE_W-1:0] vf_reg, vf_next;
    logic [BYTE_W-1:0] v0_reg, v0_next;

    // V0..VE live in a small memory with registered reads. VF is kept in its
    // own register so that a flag write and a VX write never collide, and V0
    // is mirrored in a register for the jump-plus-offset instruction.
    logic [BYTE_W-1:0]     vmem [VREG_COUNT];
    logic [VREG_COUNT-1:0] vvalid_reg;
    logic                  vmem_wr_en;

    // Input register.
    logic                in_valid_reg, in_valid_next;
    logic [OPCODE_W-1:0] in_opcode_reg;
    logic [RANDOM_W-1:0] in_random_reg;
    logic [BYTE_W-1:0]   vx_rd_reg;
    logic [BYTE_W-1:0]   vy_rd_reg;

    // Result register.
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic                s_accept;
    logic                fire;
    logic [REGIDX_W-1:0] s_x;
    logic [REGIDX_W-1:0] s_y;
    logic [REGIDX_W-1:0] ex_x;
    logic [BYTE_W-1:0]   dest_value;
    exec_t               ex;
    stack_stat_t         stk;

    // The execute stage fires when it holds an instruction and the result
    // register is free or being emptied in this cycle.
    assign fire     = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_accept = s_tvalid && s_tready;

    assign s_x  = s_tdata[11:8];
    assign s_y  = s_tdata[7:4];
    assign ex_x = in_opcode_reg[11:8];

    c8ie_exec u_exec (
        .opcode      (in_opcode_reg),
        .random_byte (in_random_reg),
        .vx          (vx_rd_reg),
        .vy          (vy_rd_reg),
        .v0          (v0_reg),
        .pc          (pc_reg),
        .idx         (idx_reg),
        .dt_value    (dt_reg),
        .stk         (stk),
        .ex          (ex)
    );

    c8ie_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fire && ex.push),
        .pop       (fire && ex.pop),
        .push_data (pc_reg + INSTR_BYTES),
        .stat      (stk)
    );

    // The start address returns to its default on reset, and the PC is
    // loaded from that restored value.
    always_comb begin
        if (!aresetn) begin
            start_addr_next = START_ADDR_RESET;
        end else if (cfg_wr_en) begin
            start_addr_next = cfg_wr_data;
        end else begin
            start_addr_next = start_addr_reg;
        end
    end

    // Next machine state. Updates only happen when the execute stage fires.
    always_comb begin
        pc_next  = pc_reg;
        idx_next = idx_reg;
        dt_next  = dt_reg;
        st_next  = st_reg;
        vf_next  = vf_reg;
        v0_next  = v0_reg;
        if (fire) begin
            pc_next = ex.npc;
            if (ex.idx_wr_en) idx_next = ex.idx_val;
            if (ex.dt_wr_en)  dt_next  = vx_rd_reg;
            if (ex.st_wr_en)  st_next  = vx_rd_reg;
            if (ex.vx_wr_en && ex_x == REG_V0) v0_next = ex.vx_val;
            // The flag is written after VX, so it wins when X is F.
            if (ex.vf_wr_en) begin
                vf_next = ex.vf_val;
            end else if (ex.vx_wr_en && ex_x == REG_VF) begin
                vf_next = ex.vx_val;
            end
        end
    end

    assign vmem_wr_en = fire && ex.vx_wr_en && (ex_x != REG_VF);

    // VX as it stands after the instruction.
    always_comb begin
        if (ex_x == REG_VF) begin
            dest_value = vf_next;
        end else if (ex.vx_wr_en) begin
            dest_value = ex.vx_val;
        end else begin
            dest_value = vx_rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_addr_reg <= START_ADDR_RESET;
            pc_reg         <= start_addr_next;
            idx_reg        <= '0;
            dt_reg         <= '0;
            st_reg         <= '0;
            vf_reg         <= '0;
            v0_reg         <= '0;
            vvalid_reg     <= '0;
            in_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            start_addr_reg <= start_addr_next;
            pc_reg         <= pc_next;
            idx_reg        <= idx_next;
            dt_reg         <= dt_next;
            st_reg         <= st_next;
            vf_reg         <= vf_next;
            v0_reg         <= v0_next;
            if (vmem_wr_en) vvalid_reg[ex_x] <= 1'b1;
            in_valid_reg   <= in_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // Register file memory: one write port, two registered read ports that
    // are loaded when a beat is accepted. A write from the instruction
    // executing in the same cycle is forwarded to the reads; an entry never
    // written since reset reads as zero.
    always_ff @(posedge aclk) begin
        if (vmem_wr_en) begin
            vmem[ex_x] <= ex.vx_val;
        end
        if (s_accept) begin
            in_opcode_reg <= s_tdata[OPCODE_W-1:0];
            in_random_reg <= s_tdata[OPCODE_W+RANDOM_W-1:OPCODE_W];
            if (s_x == REG_VF) begin
                vx_rd_reg <= vf_next;
            end else if (vmem_wr_en && ex_x == s_x) begin
                vx_rd_reg <= ex.vx_val;
            end else if (vvalid_reg[s_x]) begin
                vx_rd_reg <= vmem[s_x];
            end else begin
                vx_rd_reg <= '0;
            end
            if (s_y == REG_VF) begin
                vy_rd_reg <= vf_next;
            end else if (vmem_wr_en && ex_x == s_y) begin
                vy_rd_reg <= ex.vx_val;
            end else if (vvalid_reg[s_y]) begin
                vy_rd_reg <= vmem[s_y];
            end else begin
                vy_rd_reg <= '0;
            end
        end
    end

    // Result beat, packed from the lowest bit up.
    always_ff @(posedge aclk) begin
        if (fire) begin
            m_tdata_reg <= {st_next, dt_next, ex.draw, ex.clr, vf_next,
                            dest_value, ex_x, idx_next, pc_next, ex.status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: src/c8ie_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8ie_exec: instruction decode and execute
// Combinational decode of one instruction word against the current machine
// state; produces the next PC, register writes, stack operations and status.
// ----------------------------------------------------------------------------
module c8ie_exec (
    input  logic [c8ie_pkg::OPCODE_W-1:0] opcode,
    input  logic [c8ie_pkg::RANDOM_W-1:0] random_byte,
    input  logic [c8ie_pkg::BYTE_W-1:0]   vx,
    input  logic [c8ie_pkg::BYTE_W-1:0]   vy,
    input  logic [c8ie_pkg::BYTE_W-1:0]   v0,
    input  logic [c8ie_pkg::ADDR_W-1:0]   pc,
    input  logic [c8ie_pkg::ADDR_W-1:0]   idx,
    input  logic [c8ie_pkg::BYTE_W-1:0]   dt_value,
    input  c8ie_pkg::stack_stat_t         stk,
    output c8ie_pkg::exec_t               ex
);
    import c8ie_pkg::*;

    logic [3:0]          grp;
    logic [3:0]          x;
    logic [3:0]          sub;
    logic [7:0]          nn;
    logic [ADDR_W-1:0]   nnn;
    logic [ADDR_W-1:0]   pc_adv;
    logic [ADDR_W-1:0]   pc_skip;
    logic [BYTE_W:0]     sum;
    exec_t               raw;

    assign grp     = opcode[15:12];
    assign x       = opcode[11:8];
    assign sub     = opcode[3:0];
    assign nn      = opcode[7:0];
    assign nnn     = opcode[11:0];
    assign pc_adv  = pc + INSTR_BYTES;
    assign pc_skip = pc + SKIP_BYTES;
    assign sum     = {1'b0, vx} + {1'b0, vy};

    always_comb begin
        raw = '0;
        raw.status = ST_OK;
        raw.npc    = pc_adv;
        unique case (grp)
            GRP_SYS: begin
                if (opcode == OP_CLS) begin
                    raw.clr = 1'b1;
                end else if (opcode == OP_RET) begin
                    if (stk.empty) begin
                        raw.status = ST_UNDERFLOW;
                    end else begin
                        raw.pop = 1'b1;
                        raw.npc = stk.tos;
                    end
                end else if (x == REG_V0) begin
                    raw.status = ST_INVALID;
                end
            end
            GRP_JP: begin
                raw.npc = nnn;
            end
            GRP_CALL: begin
                if (stk.full) begin
                    raw.status = ST_OVERFLOW;
                end else begin
                    raw.push = 1'b1;
                    raw.npc  = nnn;
                end
            end
            GRP_SE_NN: begin
                if (vx == nn) raw.npc = pc_skip;
            end
            GRP_SNE_NN: begin
                if (vx != nn) raw.npc = pc_skip;
            end
            GRP_SE_XY: begin
                if (vx == vy) raw.npc = pc_skip;
            end
            GRP_LD_NN: begin
                raw.vx_wr_en = 1'b1;
                raw.vx_val   = nn;
            end
            GRP_ADD_NN: begin
                raw.vx_wr_en = 1'b1;
                raw.vx_val   = vx + nn;
            end
            GRP_ALU: begin
                raw.vx_wr_en = 1'b1;
                unique case (sub)
                    ALU_LD:  raw.vx_val = vy;
                    ALU_OR:  raw.vx_val = vx | vy;
                    ALU_AND: raw.vx_val = vx & vy;
                    ALU_XOR: raw.vx_val = vx ^ vy;
                    ALU_ADD: begin
                        raw.vx_val   = sum[BYTE_W-1:0];
                        raw.vf_wr_en = 1'b1;
                        raw.vf_val   = {7'd0, sum[BYTE_W]};
                    end
                    ALU_SUB: begin
                        raw.vx_val   = vx - vy;
                        raw.vf_wr_en = 1'b1;
                        raw.vf_val   = {7'd0, (vx >= vy)};
                    end
                    ALU_SHR: begin
                        raw.vx_val   = {1'b0, vx[7:1]};
                        raw.vf_wr_en = 1'b1;
                        raw.vf_val   = {7'd0, vx[0]};
                    end
                    ALU_SUBN: begin
                        raw.vx_val   = vy - vx;
                        raw.vf_wr_en = 1'b1;
                        raw.vf_val   = {7'd0, (vy >= vx)};
                    end
                    ALU_SHL: begin
                        raw.vx_val   = {vx[6:0], 1'b0};
                        raw.vf_wr_en = 1'b1;
                        raw.vf_val   = {7'd0, vx[7]};
                    end
                    default: begin
                        raw.status = ST_INVALID;
                    end
                endcase
            end
            GRP_SNE_XY: begin
                if (vx != vy) raw.npc = pc_skip;
            end
            GRP_LD_I: begin
                raw.idx_wr_en = 1'b1;
                raw.idx_val   = nnn;
            end
            GRP_JP_V0: begin
                raw.npc = nnn + {4'd0, v0};
            end
            GRP_RND: begin
                raw.vx_wr_en = 1'b1;
                raw.vx_val   = random_byte & nn;
            end
            GRP_DRAW: begin
                raw.vf_wr_en = 1'b1;
                raw.vf_val   = '0;
                raw.draw     = 1'b1;
            end
            GRP_KEY: begin
                if (nn != KEY_SKP && nn != KEY_SKNP) raw.status = ST_INVALID;
            end
            GRP_MISC: begin
                unique case (nn)
                    MISC_LD_VX_DT: begin
                        raw.vx_wr_en = 1'b1;
                        raw.vx_val   = dt_value;
                    end
                    MISC_LD_DT: raw.dt_wr_en = 1'b1;
                    MISC_LD_ST: raw.st_wr_en = 1'b1;
                    MISC_ADD_I: begin
                        raw.idx_wr_en = 1'b1;
                        raw.idx_val   = idx + {4'd0, vx};
                    end
                    MISC_LD_KEY, MISC_LD_FONT, MISC_BCD, MISC_STORE, MISC_LOAD: begin
                    end
                    default: raw.status = ST_INVALID;
                endcase
            end
        endcase

        // A failed instruction leaves every piece of state alone.
        ex = raw;
        if (raw.status != ST_OK) begin
            ex.npc       = pc;
            ex.vx_wr_en  = 1'b0;
            ex.vf_wr_en  = 1'b0;
            ex.idx_wr_en = 1'b0;
            ex.dt_wr_en  = 1'b0;
            ex.st_wr_en  = 1'b0;
            ex.push      = 1'b0;
            ex.pop       = 1'b0;
            ex.clr       = 1'b0;
            ex.draw      = 1'b0;
        end
    end

endmodule

// File: src/c8ie_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8ie_stack: subroutine return stack
// The top entry lives in a register; deeper entries live in a memory whose
// registered read port always holds the entry just below the top.
// ----------------------------------------------------------------------------
module c8ie_stack #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  logic                        pop,
    input  logic [c8ie_pkg::ADDR_W-1:0] push_data,
    output c8ie_pkg::stack_stat_t       stat
);
    import c8ie_pkg::*;

    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int AW   = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);
    localparam logic [SP_W-1:0] SP_ONE  = SP_W'(1);
    localparam logic [SP_W-1:0] SP_TWO  = SP_W'(2);

    logic [ADDR_W-1:0] mem [STACK_DEPTH];
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [ADDR_W-1:0] tos_reg, tos_next;
    logic [ADDR_W-1:0] below_reg;
    logic [SP_W-1:0]   wr_level;
    logic [SP_W-1:0]   rd_level;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;

    // Pushing spills the old top into the memory one level down.
    assign wr_en    = push && (sp_reg != '0);
    assign wr_level = sp_reg - SP_ONE;
    assign wr_addr  = wr_level[AW-1:0];
    assign rd_level = (sp_next >= SP_TWO) ? (sp_next - SP_TWO) : '0;
    assign rd_addr  = rd_level[AW-1:0];

    always_comb begin
        sp_next  = sp_reg;
        tos_next = tos_reg;
        if (push) begin
            sp_next  = sp_reg + SP_ONE;
            tos_next = push_data;
        end else if (pop) begin
            sp_next  = sp_reg - SP_ONE;
            tos_next = below_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg <= '0;
        end else begin
            sp_reg <= sp_next;
        end
    end

    always_ff @(posedge aclk) begin
        tos_reg <= tos_next;
        if (wr_en) begin
            mem[wr_addr] <= tos_reg;
        end
        if (wr_en && wr_addr == rd_addr) begin
            below_reg <= tos_reg;
        end else begin
            below_reg <= mem[rd_addr];
        end
    end

    assign stat.empty = (sp_reg == '0);
    assign stat.full  = (sp_reg == SP_FULL);
    assign stat.tos   = tos_reg;

endmodule

// File: dv/chip8_instruction_execute_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_instruction_execute_tb: self-checking bench for the CHIP-8 executor
// Streams instruction beats into the block and keeps its own copy of the
// machine state: registers, index, PC, call stack and timers. Every result
// beat is compared field by field with the state that copy predicts. The run
// has a short directed part, a call-depth test, and random instruction
// streams under several idle and stall patterns. It also has a long receiver
// hold-off, and writes the start address register between phases.
// ----------------------------------------------------------------------------
module chip8_instruction_execute_tb;
    import c8ie_pkg::*;

    localparam int STACK_DEPTH = 16;
    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 90;
    localparam int DRAIN_WAIT  = 20;

    // One result beat. The first member sits in the top bits, so the fields
    // are listed here from the highest bit down to match m_tdata.
    typedef struct packed {
        logic [BYTE_W-1:0]   sound;
        logic [BYTE_W-1:0]   delay;
        logic                draw;
        logic                clr;
        logic [BYTE_W-1:0]   vf;
        logic [BYTE_W-1:0]   vx;
        logic [REGIDX_W-1:0] x;
        logic [ADDR_W-1:0]   index;
        logic [ADDR_W-1:0]   pc;
        status_t             status;
    } machine_report_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [ADDR_W-1:0]    cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    chip8_instruction_execute #(
        .STACK_DEPTH (STACK_DEPTH)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Machine state as the bench expects it to be.
    // ------------------------------------------------------------------------
    logic [BYTE_W-1:0] vreg [VREG_COUNT];
    logic [ADDR_W-1:0] i_reg;
    logic [ADDR_W-1:0] pc;
    logic [ADDR_W-1:0] call_stack [STACK_DEPTH];
    int                call_depth;
    logic [BYTE_W-1:0] delay_reg;
    logic [BYTE_W-1:0] sound_reg;
    logic [ADDR_W-1:0] boot_addr;

    machine_report_t pending_states [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_ticket    = 0;
    int error_count    = 0;
    int cycle_count    = 0;
    int beats_sent     = 0;
    int beats_checked  = 0;
    int fault_beats    = 0;
    int deepest_call   = 0;
    int cfg_writes     = 0;

    function automatic void reset_machine();
        foreach (vreg[k]) vreg[k] = '0;
        foreach (call_stack[k]) call_stack[k] = '0;
        boot_addr  = START_ADDR_RESET;
        pc         = boot_addr;
        i_reg      = '0;
        call_depth = 0;
        delay_reg  = '0;
        sound_reg  = '0;
    endfunction

    // Executes one instruction on the bench's machine state and returns the
    // state the block should report for it.
    function automatic machine_report_t execute_instr(input logic [OPCODE_W-1:0] op,
                                                      input logic [RANDOM_W-1:0] rnd);
        logic [REGIDX_W-1:0] x;
        logic [REGIDX_W-1:0] y;
        logic [BYTE_W-1:0]   nn;
        logic [BYTE_W-1:0]   vx;
        logic [BYTE_W-1:0]   vy;
        logic [ADDR_W-1:0]   nnn;
        logic [ADDR_W-1:0]   npc;
        logic [BYTE_W:0]     sum;
        status_t             st;
        logic                clr;
        logic                draw;
        machine_report_t     r;
        x    = op[11:8];
        y    = op[7:4];
        nn   = op[7:0];
        nnn  = op[11:0];
        vx   = vreg[x];
        vy   = vreg[y];
        st   = ST_OK;
        clr  = 1'b0;
        draw = 1'b0;
        npc  = pc + INSTR_BYTES;
        case (op[15:12])
            GRP_SYS: begin
                if (op == OP_CLS) begin
                    clr = 1'b1;
                end else if (op == OP_RET) begin
                    if (call_depth == 0) begin
                        st = ST_UNDERFLOW;
                    end else begin
                        call_depth--;
                        npc = call_stack[call_depth];
                    end
                end else if (x == REG_V0) begin
                    st = ST_INVALID;
                end
            end
            GRP_JP:     npc = nnn;
            GRP_CALL: begin
                if (call_depth >= STACK_DEPTH) begin
                    st = ST_OVERFLOW;
                end else begin
                    call_stack[call_depth] = pc + INSTR_BYTES;
                    call_depth++;
                    npc = nnn;
                end
            end
            GRP_SE_NN:  if (vx == nn) npc = pc + SKIP_BYTES;
            GRP_SNE_NN: if (vx != nn) npc = pc + SKIP_BYTES;
            GRP_SE_XY:  if (vx == vy) npc = pc + SKIP_BYTES;
            GRP_LD_NN:  vreg[x] = nn;
            GRP_ADD_NN: vreg[x] = vx + nn;
            GRP_ALU: begin
                // The flag is written after the result, so VF keeps the flag
                // when it is also the destination.
                case (op[3:0])
                    ALU_LD:  vreg[x] = vy;
                    ALU_OR:  vreg[x] = vx | vy;
                    ALU_AND: vreg[x] = vx & vy;
                    ALU_XOR: vreg[x] = vx ^ vy;
                    ALU_ADD: begin
                        sum          = {1'b0, vx} + {1'b0, vy};
                        vreg[x]      = sum[BYTE_W-1:0];
                        vreg[REG_VF] = {7'd0, sum[BYTE_W]};
                    end
                    ALU_SUB: begin
                        vreg[x]      = vx - vy;
                        vreg[REG_VF] = {7'd0, vx >= vy};
                    end
                    ALU_SHR: begin
                        vreg[x]      = vx >> 1;
                        vreg[REG_VF] = {7'd0, vx[0]};
                    end
                    ALU_SUBN: begin
                        vreg[x]      = vy - vx;
                        vreg[REG_VF] = {7'd0, vy >= vx};
                    end
                    ALU_SHL: begin
                        vreg[x]      = vx << 1;
                        vreg[REG_VF] = {7'd0, vx[7]};
                    end
                    default: st = ST_INVALID;
                endcase
            end
            GRP_SNE_XY: if (vx != vy) npc = pc + SKIP_BYTES;
            GRP_LD_I:   i_reg = nnn;
            GRP_JP_V0:  npc = nnn + {4'd0, vreg[REG_V0]};
            GRP_RND:    vreg[x] = rnd & nn;
            GRP_DRAW: begin
                vreg[REG_VF] = '0;
                draw         = 1'b1;
            end
            GRP_KEY: begin
                if (nn != KEY_SKP && nn != KEY_SKNP) st = ST_INVALID;
            end
            GRP_MISC: begin
                case (nn)
                    MISC_LD_VX_DT: vreg[x] = delay_reg;
                    MISC_LD_DT:    delay_reg = vx;
                    MISC_LD_ST:    sound_reg = vx;
                    MISC_ADD_I:    i_reg = i_reg + {4'd0, vx};
                    MISC_LD_KEY, MISC_LD_FONT, MISC_BCD, MISC_STORE, MISC_LOAD: ;
                    default:       st = ST_INVALID;
                endcase
            end
            default: ;
        endcase
        if (st == ST_OK) begin
            pc = npc;
        end else begin
            clr  = 1'b0;
            draw = 1'b0;
        end
        r.status = st;
        r.pc     = pc;
        r.index  = i_reg;
        r.x      = x;
        r.vx     = vreg[x];
        r.vf     = vreg[REG_VF];
        r.clr    = clr;
        r.draw   = draw;
        r.delay  = delay_reg;
        r.sound  = sound_reg;
        return r;
    endfunction

    // Random instruction word. Sub-codes are mostly valid ones, and skips are
    // often steered toward the equal case so both outcomes are common.
    function automatic logic [OPCODE_W-1:0] rand_instr();
        logic [3:0]          grp;
        logic [REGIDX_W-1:0] x;
        logic [BYTE_W-1:0]   nn;
        logic [OPCODE_W-1:0] op;
        int                  pick;
        pick = $urandom_range(16);
        x    = REGIDX_W'($urandom_range(15));
        nn   = BYTE_W'($urandom_range(255));
        grp  = pick[3:0];
        op   = {grp, x, nn};
        if (pick == 16) begin
            op = OP_RET;
        end else begin
            case (grp)
                GRP_SYS: begin
                    case ($urandom_range(3))
                        0: op = OP_CLS;
                        1: op = OP_RET;
                        2: op = {GRP_SYS, 4'($urandom_range(15, 1)), nn};
                        default: op = {8'h00, nn};
                    endcase
                end
                GRP_SE_NN, GRP_SNE_NN: if ($urandom_range(1) == 0) op[7:0] = vreg[x];
                GRP_SE_XY, GRP_SNE_XY: if ($urandom_range(2) == 0) op[7:4] = x;
                GRP_ALU: begin
                    case ($urandom_range(9))
                        0: op[3:0] = ALU_LD;
                        1: op[3:0] = ALU_OR;
                        2: op[3:0] = ALU_AND;
                        3: op[3:0] = ALU_XOR;
                        4: op[3:0] = ALU_ADD;
                        5: op[3:0] = ALU_SUB;
                        6: op[3:0] = ALU_SHR;
                        7: op[3:0] = ALU_SUBN;
                        8: op[3:0] = ALU_SHL;
                        default: ;
                    endcase
                end
                GRP_KEY: begin
                    case ($urandom_range(3))
                        0: op[7:0] = KEY_SKP;
                        1: op[7:0] = KEY_SKNP;
                        default: ;
                    endcase
                end
                GRP_MISC: begin
                    case ($urandom_range(11))
                        0: op[7:0] = MISC_LD_VX_DT;
                        1: op[7:0] = MISC_LD_KEY;
                        2: op[7:0] = MISC_LD_DT;
                        3: op[7:0] = MISC_LD_ST;
                        4: op[7:0] = MISC_ADD_I;
                        5: op[7:0] = MISC_LD_FONT;
                        6: op[7:0] = MISC_BCD;
                        7: op[7:0] = MISC_STORE;
                        8: op[7:0] = MISC_LOAD;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        return op;
    endfunction

    // ------------------------------------------------------------------------
    // Input side. A beat is offered after a random number of idle cycles and
    // held until the block takes it; the expected state is recorded at the
    // edge where it is accepted.
    // ------------------------------------------------------------------------
    task automatic send_instr(input logic [OPCODE_W-1:0] op, input logic [RANDOM_W-1:0] rnd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rnd, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_states.push_back(execute_instr(op, rnd));
        beats_sent++;
        if (call_depth > deepest_call) deepest_call = call_depth;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_instr(rand_instr(), 8'($urandom_range(255)));
    endtask

    // Stops offering beats, waits until every expected result has come back,
    // then writes the start address. The write does not move the PC, so
    // the running PC must carry on untouched.
    task automatic write_start_addr(input logic [ADDR_W-1:0] addr);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_states.size() != 0) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= addr;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        boot_addr = addr;
        cfg_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Result side. The receiver stalls at random, or for a long hold-off each
    // time a test raises the hold ticket.
    // ------------------------------------------------------------------------
    int hold_seen = 0;
    int hold_left = 0;

    always @(posedge aclk) begin
        if (hold_ticket != hold_seen) begin
            hold_seen = hold_ticket;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void check_field(input string name, input logic [ADDR_W-1:0] exp_val,
                                        input logic [ADDR_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_val, act_val);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        machine_report_t want;
        machine_report_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = machine_report_t'(m_tdata);
            if (pending_states.size() == 0) begin
                $display("%0t ns: result beat with nothing expected, actual 0x%016h",
                         $time, m_tdata);
                error_count++;
            end else begin
                want = pending_states.pop_front();
                check_field("status",       12'(want.status), 12'(got.status));
                check_field("next_pc",      want.pc,          got.pc);
                check_field("index_value",  want.index,       got.index);
                check_field("dest_reg",     12'(want.x),      12'(got.x));
                check_field("dest_value",   12'(want.vx),     12'(got.vx));
                check_field("flag_value",   12'(want.vf),     12'(got.vf));
                check_field("clear_screen", 12'(want.clr),    12'(got.clr));
                check_field("draw_request", 12'(want.draw),   12'(got.draw));
                check_field("delay_value",  12'(want.delay),  12'(got.delay));
                check_field("sound_value",  12'(want.sound),  12'(got.sound));
                if (want.status != ST_OK) fault_beats++;
            end
            beats_checked++;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycle_count, pending_states.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Corner cases of each instruction group, in an order where each one
    // sets up the register values the next relies on.
    task automatic test_directed();
        send_instr(OP_RET, 8'h00);                       // return with empty stack
        send_instr(16'h0000, 8'h00);                     // group zero, invalid
        send_instr(16'h0ABC, 8'h00);                     // machine-code call, ignored
        send_instr(OP_CLS, 8'h00);
        send_instr(16'h60FF, 8'h00);
        send_instr(16'h6E01, 8'h00);
        send_instr(16'h70FF, 8'h00);                     // 8-bit add wraps, VF kept
        send_instr(16'h80E4, 8'h00);                     // add, no carry
        send_instr(16'h8E04, 8'h00);                     // add, carry out
        send_instr(16'h8F05, 8'h00);                     // VF is destination of sub
        send_instr(16'h8005, 8'h00);                     // equal operands: no borrow
        send_instr(16'h8E07, 8'h00);                     // reverse sub, equal
        send_instr(16'h6181, 8'h00);
        send_instr(16'h811E, 8'h00);                     // shift left, Y ignored
        send_instr(16'h81F6, 8'h00);                     // shift right, Y ignored
        send_instr(16'h8128, 8'h00);                     // unused ALU code
        send_instr(16'h8FFF, 8'h00);
        send_instr(16'hCFFF, 8'hA5);                     // full random byte mask
        send_instr(16'hD123, 8'h00);
        send_instr(16'hAFFF, 8'h00);
        send_instr(16'hF11E, 8'h00);                     // 12-bit index wraps
        send_instr(16'hF115, 8'h00);
        send_instr(16'hF218, 8'h00);
        send_instr(16'hF307, 8'h00);
        send_instr(16'hF033, 8'h00);                     // advance only
        send_instr(16'hF0FF, 8'h00);                     // unlisted misc code
        send_instr(16'hE09E, 8'h00);
        send_instr(16'hE000, 8'h00);                     // unlisted key code
        send_instr(16'h3301, 8'h00);                     // skip taken
        send_instr(16'h5317, 8'h00);                     // low nibble not checked
        send_instr(16'h1FFE, 8'h00);
        send_instr(16'h2FFE, 8'h00);                     // call from the top of memory
        send_instr(OP_RET, 8'h00);
        send_instr(16'hBFFF, 8'h00);                     // jump plus V0 to the last address
    endtask

    // Calls nest until the stack is full and one more overflows, then returns
    // unwind it until one more underflows. Targets are random.
    task automatic test_call_depth();
        repeat (2) begin
            repeat (STACK_DEPTH + 1) begin
                send_instr({GRP_CALL, 12'($urandom_range(4095))}, 8'($urandom_range(255)));
            end
            repeat (STACK_DEPTH + 1) send_instr(OP_RET, 8'($urandom_range(255)));
        end
    endtask

    task automatic test_random_stream(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        send_random(count);
    endtask

    // The receiver holds off long enough for the result and input registers
    // to fill, so s_tready drops while the sender keeps offering beats.
    task automatic test_backpressure(input int count);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (2) begin
            hold_ticket++;
            send_random(count / 2);
        end
    endtask

    initial begin
        reset_machine();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_start_addr(12'hFFF);
        test_directed();
        write_start_addr(12'h000);
        test_call_depth();
        write_start_addr(12'($urandom_range(4095)));
        test_random_stream(350, 0, 0);
        write_start_addr(START_ADDR_RESET);
        test_random_stream(350, 64, 0);
        write_start_addr(12'hFFF);
        test_random_stream(350, 0, 64);
        write_start_addr(12'($urandom_range(4095)));
        test_random_stream(350, 18, 18);
        write_start_addr(12'h000);
        test_backpressure(350);

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_states.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Ran %0d instructions, %0d results checked, %0d with a fault status",
                 beats_sent, beats_checked, fault_beats);
        $display("Deepest call nesting %0d, %0d start address writes, %0d cycles",
                 deepest_call, cfg_writes, cycle_count);
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/c8ie_pkg.sv
src/c8ie_exec.sv
src/c8ie_stack.sv
src/chip8_instruction_execute.sv
dv/chip8_instruction_execute_tb.sv
